// ===== design/fce_pkg.sv =====
// ----------------------------------------------------------------------------
// fce_pkg - shared constants for the field convergence check
// Widths of the Q16.16 datapath, the factor registers and the register map.
// ----------------------------------------------------------------------------
package fce_pkg;

    localparam int Q_W      = 32;               // Q16.16 value width
    localparam int FACT_W   = 24;               // Q8.16 weight width
    localparam int HALF_W   = 16;               // multiplier operand slice
    localparam int PP_W     = FACT_W + HALF_W;  // partial product width
    localparam int PROD_W   = FACT_W + Q_W;     // full weighted difference
    localparam int NUM_HI_W = PROD_W - Q_W;     // dividend bits above quotient
    localparam int DCNT_W   = 5;                // one count per quotient bit

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ABS_FACTOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REL_FACTOR = 2'd1;

    localparam logic [FACT_W-1:0] FACT_RESET = 24'h01_0000;  // 1.0
    localparam logic [Q_W-1:0]    ONE_Q16    = 32'h0001_0000;
    localparam logic [Q_W-1:0]    SAT_Q      = 32'hFFFF_FFFF;

endpackage

// ===== design/fce_div.sv =====
// ----------------------------------------------------------------------------
// fce_div - radix-2 restoring divider with saturating 32-bit quotient
// Divides {num_hi, num_lo} by den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fce_div
    import fce_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_HI_W-1:0] num_hi,
    input  logic [Q_W-1:0]      num_lo,
    input  logic [Q_W-1:0]      den,
    output logic                done,
    output logic [Q_W-1:0]      quot
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [Q_W-1:0]    rem_reg;
    logic [Q_W-1:0]    sh_reg;   // dividend bits out at the top, quotient in
    logic [Q_W-1:0]    den_reg;

    logic [Q_W:0]      trial;
    logic              q_bit;
    logic [Q_W-1:0]    rem_next;
    logic              ovf;

    assign trial    = {rem_reg, sh_reg[Q_W-1]};
    assign q_bit    = (trial >= {1'b0, den_reg});
    assign rem_next = q_bit ? Q_W'(trial - {1'b0, den_reg}) : trial[Q_W-1:0];
    // quotient would need more than 32 bits
    assign ovf      = ({{(Q_W-NUM_HI_W){1'b0}}, num_hi} >= den);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                den_reg <= den;
                if (ovf) begin
                    sh_reg   <= SAT_Q;
                    done_reg <= 1'b1;
                end else begin
                    rem_reg  <= {{(Q_W-NUM_HI_W){1'b0}}, num_hi};
                    sh_reg   <= num_lo;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                sh_reg  <= {sh_reg[Q_W-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(Q_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ===== design/field_convergence_error_check.sv =====
// ----------------------------------------------------------------------------
// field_convergence_error_check - mixed tolerance convergence check
// Per-round maximum of min(absolute, relative) node error in Q16.16.
// ----------------------------------------------------------------------------
// One item is one node value of the current solver round; the item with
// s_last_node set closes the round and yields one result: the round maximum
// of the mixed error and a converged flag (error at most 1.0, never in the
// first round). Previous round values live in a MAX_NODES deep memory that
// is read and rewritten at the node's slot on acceptance; a round longer
// than every earlier one reads unwritten slots and gives undefined errors.
// After acceptance an item keeps the block busy until it is done, so a new
// item is taken only once the last one is through: the memory read and
// difference, the weighted products on a shared 24x16 multiplier, the
// relative error (a start state, 32 quotient bits at one per cycle in the
// radix-2 divider and a wait to see it done), and the fold of the error
// into the round maximum. A relative error that would overflow 32 bits is
// caught at divider start, which then returns all ones without forming
// quotient bits. Items with a zero node value skip the divider; items in
// the first round form no error and skip the products as well.
// A closing item also waits while an earlier result is still held on the
// m_ side. Configuration writes are always taken; write them only while
// the block is idle.
// ----------------------------------------------------------------------------
module field_convergence_error_check
    import fce_pkg::*;
#(
    parameter int MAX_NODES = 4096
)
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic signed [Q_W-1:0] s_node_value,
    input  logic                 s_last_node,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [Q_W-1:0]       m_error_estimate,
    output logic                 m_converged,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FACT_W-1:0]    cfg_data
);

    localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_MUL,
        S_DIVGO,
        S_DIVWAIT,
        S_FIN
    } state_t;

    state_t             state_reg;
    logic [AW-1:0]      node_index_reg;
    logic               first_round_reg;
    logic [Q_W-1:0]     running_error_reg;
    logic [FACT_W-1:0]  abs_factor_reg;
    logic [FACT_W-1:0]  rel_factor_reg;

    // item being worked on
    logic [Q_W-1:0]     now_reg;
    logic               last_reg;
    logic [Q_W-1:0]     old_reg;
    logic [Q_W-1:0]     mag_reg;
    logic [Q_W-1:0]     den_reg;
    logic               zero_now_reg;
    logic [1:0]         step_reg;
    logic [PROD_W-1:0]  acc_reg;
    logic [Q_W-1:0]     abs_err_reg;

    logic               m_valid_reg;
    logic [Q_W-1:0]     m_error_reg;
    logic               m_conv_reg;

    // previous round values
    logic [Q_W-1:0]     prev_mem [MAX_NODES];

    logic               in_acc;
    logic [Q_W:0]       diff;
    logic [Q_W-1:0]     mag;
    logic [Q_W-1:0]     den_abs;
    logic [FACT_W-1:0]  mul_fact;
    logic [HALF_W-1:0]  mul_half;
    logic [PP_W-1:0]    pp;
    logic [PROD_W-1:0]  acc_next;
    logic [Q_W-1:0]     abs_sat;
    logic               div_start;
    logic               div_done;
    logic [Q_W-1:0]     div_quot;
    logic [Q_W-1:0]     err_mix;
    logic [Q_W-1:0]     run_max;
    logic               out_free;
    logic               out_load;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // read-before-write: the old value comes out as the new one goes in
    always_ff @(posedge aclk) begin
        if (in_acc) begin
            prev_mem[node_index_reg] <= s_node_value;
            old_reg                  <= prev_mem[node_index_reg];
        end
    end

    // 33-bit signed difference; magnitude always fits 32 bits
    assign diff    = {now_reg[Q_W-1], now_reg} - {old_reg[Q_W-1], old_reg};
    assign mag     = diff[Q_W] ? Q_W'(~diff + 1'b1) : diff[Q_W-1:0];
    assign den_abs = now_reg[Q_W-1] ? (~now_reg + 1'b1) : now_reg;

    // shared multiplier: step 0/1 abs weight, 2/3 rel weight; odd = high half
    assign mul_fact = step_reg[1] ? rel_factor_reg : abs_factor_reg;
    assign mul_half = step_reg[0] ? mag_reg[Q_W-1:HALF_W] : mag_reg[HALF_W-1:0];
    assign pp       = PP_W'(mul_fact) * PP_W'(mul_half);
    assign acc_next = step_reg[0] ? (acc_reg + {pp, {HALF_W{1'b0}}})
                                  : PROD_W'(pp);

    // abs error = product >> 16, saturated
    assign abs_sat = (|acc_reg[PROD_W-1:Q_W+HALF_W]) ? SAT_Q
                                                    : acc_reg[Q_W+HALF_W-1:HALF_W];

    assign div_start = (state_reg == S_DIVGO);

    fce_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num_hi  (acc_reg[PROD_W-1:Q_W]),
        .num_lo  (acc_reg[Q_W-1:0]),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // zero node value: relative error is infinite, absolute wins
    assign err_mix = (zero_now_reg || (abs_err_reg < div_quot)) ? abs_err_reg
                                                                 : div_quot;
    assign run_max = (err_mix > running_error_reg) ? err_mix : running_error_reg;
    assign out_free = !m_valid_reg || m_ready;
    // closing item hands its result to the output register
    assign out_load = (state_reg == S_FIN) && last_reg && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            node_index_reg    <= '0;
            first_round_reg   <= 1'b1;
            running_error_reg <= '0;
            abs_factor_reg    <= FACT_RESET;
            rel_factor_reg    <= FACT_RESET;
            step_reg          <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                if (cfg_index == REG_ABS_FACTOR) begin
                    abs_factor_reg <= cfg_data;
                end else if (cfg_index == REG_REL_FACTOR) begin
                    rel_factor_reg <= cfg_data;
                end
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        now_reg   <= s_node_value;
                        last_reg  <= s_last_node;
                        state_reg <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    mag_reg      <= mag;
                    den_reg      <= den_abs;
                    zero_now_reg <= (now_reg == '0);
                    step_reg     <= '0;
                    state_reg    <= first_round_reg ? S_FIN : S_MUL;
                end
                S_MUL: begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd2) begin
                        abs_err_reg <= abs_sat;
                    end
                    if (step_reg == 2'd3) begin
                        state_reg <= zero_now_reg ? S_FIN : S_DIVGO;
                    end
                end
                S_DIVGO: begin
                    state_reg <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (div_done) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!last_reg) begin
                        if (!first_round_reg) begin
                            running_error_reg <= run_max;
                        end
                        node_index_reg <= (node_index_reg == AW'(MAX_NODES - 1))
                                          ? '0 : node_index_reg + 1'b1;
                        state_reg      <= S_IDLE;
                    end else if (out_free) begin
                        m_error_reg       <= first_round_reg ? '0 : run_max;
                        m_conv_reg        <= !first_round_reg && (run_max <= ONE_Q16);
                        first_round_reg   <= 1'b0;
                        running_error_reg <= '0;
                        node_index_reg    <= '0;
                        state_reg         <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_error_estimate = m_error_reg;
    assign m_converged      = m_conv_reg;

endmodule

// ===== sim/tb_field_convergence_error_check.sv =====
// ----------------------------------------------------------------------------
// tb_field_convergence_error_check - self-checking bench for the convergence check
// Drives node items over the s_ channel and results are checked on the m_
// channel against an in-bench predictor. The run opens with a first round
// as long as the longest random round, then a table of directed items and
// register writes, then random rounds across several factor settings.
// ----------------------------------------------------------------------------
module tb_field_convergence_error_check
    import fce_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES     = 4096;
    localparam int OPEN_NODES    = 150;
    localparam int RANDOM_ITEMS  = 985;
    localparam int PHASE_ITEMS   = 128;
    // Enough for the block's worst item plus margin before touching the
    // registers or closing the run.
    localparam int SETTLE_CYCLES = 64;
    // No handshake on any channel for this long means the block has hung.
    localparam int HANG_LIMIT    = 4000;

    // Register indexes the block has no register behind; writes must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [Q_W-1:0] error_estimate;
        logic           converged;
    } round_result_t;

    typedef enum logic {STEP_NODE, STEP_REG} step_kind_e;

    // One row of the directed table: a node item or a register write.
    // Where 'typed' is set the expected result is given here; otherwise the
    // predictor supplies it.
    typedef struct packed {
        step_kind_e           kind;
        logic [CFG_IDX_W-1:0] reg_index;
        logic [Q_W-1:0]       value;
        logic                 last;
        logic                 typed;
        logic [Q_W-1:0]       exp_error;
        logic                 exp_converged;
    } directed_step_t;

    typedef enum logic [1:0] {ROUND_SETTLING, ROUND_MIXED, ROUND_NOISE} round_mode_e;

    // ------------------------------------------------------------------------
    // DUT signals, all driven to known values from time zero
    // ------------------------------------------------------------------------
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [Q_W-1:0]       s_node_value = '0;
    logic                 s_last_node  = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [Q_W-1:0]       m_error_estimate;
    logic                 m_converged;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [FACT_W-1:0]    cfg_data     = '0;

    field_convergence_error_check #(
        .MAX_NODES (MAX_NODES)
    ) u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_node_value     (s_node_value),
        .s_last_node      (s_last_node),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_error_estimate (m_error_estimate),
        .m_converged      (m_converged),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: mirrors what the block must hold
    // ------------------------------------------------------------------------
    logic [Q_W-1:0]    prior_vals [MAX_NODES];  // last round's value per slot
    bit                first_pass = 1'b1;       // no errors formed in first round
    logic [Q_W-1:0]    round_max  = '0;         // running maximum of mixed error
    int unsigned       slot       = 0;          // node position within the round
    logic [FACT_W-1:0] abs_w      = FACT_RESET;
    logic [FACT_W-1:0] rel_w      = FACT_RESET;

    round_result_t pending_rounds[$];           // results still owed by the block
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    bit            calm           = 1'b0;       // suppresses idling on both sides

    // Mixed error of one node: smaller of the weighted absolute difference
    // and the weighted difference over |new|, each clamped to 32 bits.
    function automatic logic [Q_W-1:0] node_error(logic [Q_W-1:0] now, logic [Q_W-1:0] old);
        longint         now_v;
        longint         old_v;
        longint         diff;
        logic [63:0]    mag;
        logic [63:0]    den;
        logic [63:0]    wide;
        logic [Q_W-1:0] abs_err;
        logic [Q_W-1:0] rel_err;
        now_v = longint'($signed(now));
        old_v = longint'($signed(old));
        diff  = now_v - old_v;
        mag   = (diff < 0) ? -diff : diff;
        wide  = ({40'b0, abs_w} * mag) >> 16;
        abs_err = (wide > 64'hFFFF_FFFF) ? SAT_Q : wide[Q_W-1:0];
        // zero new value: relative error is taken as infinite
        if (now_v == 0)
            return abs_err;
        den  = (now_v < 0) ? -now_v : now_v;
        wide = ({40'b0, rel_w} * mag) / den;
        rel_err = (wide > 64'hFFFF_FFFF) ? SAT_Q : wide[Q_W-1:0];
        return (abs_err < rel_err) ? abs_err : rel_err;
    endfunction

    // Advance the predictor by one accepted item; a closing item queues
    // its result (or the typed one from the directed table).
    function automatic void absorb_node(logic [Q_W-1:0] now, bit last, bit typed,
                                        logic [Q_W-1:0] t_err, bit t_conv);
        round_result_t  res;
        logic [Q_W-1:0] e;
        if (!first_pass) begin
            e = node_error(now, prior_vals[slot]);
            if (e > round_max)
                round_max = e;
        end
        prior_vals[slot] = now;
        if (!last) begin
            // long rounds wrap and reuse the low slots
            slot = (slot == MAX_NODES - 1) ? 0 : slot + 1;
            return;
        end
        res.error_estimate = first_pass ? '0 : round_max;
        res.converged      = !first_pass && (round_max <= ONE_Q16);
        if (typed) begin
            res.error_estimate = t_err;
            res.converged      = t_conv;
        end
        pending_rounds.insert(pending_rounds.size(), res);
        first_pass = 1'b0;
        round_max  = '0;
        slot       = 0;
    endfunction

    // Node value for random rounds. Most values sit close to the stored one
    // so that errors land around the 1.0 threshold.
    function automatic logic [Q_W-1:0] pick_value(round_mode_e mode);
        int unsigned    roll;
        int unsigned    k;
        logic [Q_W-1:0] delta;
        logic [Q_W-1:0] base;
        roll = $urandom_range(0, 99);
        base = prior_vals[slot];
        case (mode)
            ROUND_SETTLING: begin
                if (roll < 10)
                    return base;
                if (roll < 15)
                    return '0;
                k = (roll < 85) ? $urandom_range(0, 14) : $urandom_range(15, 20);
            end
            ROUND_MIXED: begin
                if (roll < 15)
                    return '0;
                if (roll < 55)
                    return $urandom;
                if (roll < 70)
                    roll = 100;  // fall through to the extremes below
                else
                    k = $urandom_range(0, 20);
            end
            default: begin
                if (roll < 80)
                    return $urandom;
                roll = 100;
            end
        endcase
        if (roll == 100) begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0001;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        delta = $urandom_range(0, 1 << k);
        return $urandom_range(0, 1) ? base + delta : base - delta;
    endfunction

    // ------------------------------------------------------------------------
    // Channel drivers. send_node leaves s_valid high on return; the next
    // call either keeps it (back-to-back) or drops it, never both in one
    // step. write_reg drops cfg_valid again before it returns.
    // ------------------------------------------------------------------------
    task automatic send_node(logic [Q_W-1:0] v, bit last, bit typed = 1'b0,
                             logic [Q_W-1:0] t_err = '0, bit t_conv = 1'b0);
        // random gap before the item, long enough to land in any phase of
        // the block's work on the previous item
        if (!calm && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_node_value <= v;
        s_last_node  <= last;
        do @(posedge aclk); while (!s_ready);
        absorb_node(v, last, typed, t_err, t_conv);
    endtask

    // Hold the sender off until every owed result is in, then give the block
    // time to finish any item that yields no result.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_rounds.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FACT_W-1:0] data);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_ABS_FACTOR)
            abs_w = data;
        else if (idx == REG_REL_FACTOR)
            rel_w = data;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and in-order field compare
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 18);
    end

    always @(posedge aclk) begin
        round_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rounds.size() == 0) begin
                $error("unexpected result: error_estimate %h converged %b",
                       m_error_estimate, m_converged);
                mismatch_count++;
            end else begin
                want = pending_rounds.pop_front();
                if (m_error_estimate !== want.error_estimate) begin
                    $error("error_estimate: expected %h, got %h",
                           want.error_estimate, m_error_estimate);
                    mismatch_count++;
                end
                if (m_converged !== want.converged) begin
                    $error("converged: expected %b, got %b", want.converged, m_converged);
                    mismatch_count++;
                end
            end
        end
    end

    // Hang watchdog: counts cycles with no handshake on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Directed table. Slots 0..2 hold 0, +max and -max after the opening
    // round, so the rows below can be read off by hand.
    // ------------------------------------------------------------------------
    localparam directed_step_t DIRECTED [22] = '{
        // unchanged zero: no error, converged
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
        // step of exactly 1.0: sits on the threshold, still converged
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0001_0000, 1'b1, 1'b1, 32'h0001_0000, 1'b1},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0002_0000, 1'b1, 1'b0, 32'h0, 1'b0},
        // zero new value: absolute error only
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0000_0000, 1'b1, 1'b1, 32'h0002_0000, 1'b0},
        // full-swing differences across three slots
        '{STEP_NODE, REG_ABS_FACTOR, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0},
        // largest absolute weight saturates the error
        '{STEP_REG,  REG_ABS_FACTOR, 32'h00FF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
        '{STEP_REG,  REG_REL_FACTOR, 32'h00FF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 1'b0},
        // zero weights: every error collapses to zero
        '{STEP_REG,  REG_ABS_FACTOR, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_REG,  REG_REL_FACTOR, 32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
        // writes to unused indexes must leave the weights alone
        '{STEP_REG,  REG_SPARE_2,    32'h00FF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_REG,  REG_SPARE_3,    32'h00FF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000, 1'b1},
        '{STEP_REG,  REG_ABS_FACTOR, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_REG,  REG_REL_FACTOR, 32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        // small and negative values
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0000_8000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'hFFFF_0000, 1'b0, 1'b0, 32'h0, 1'b0},
        '{STEP_NODE, REG_ABS_FACTOR, 32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int                random_items;
        int                phase_items;
        int                phase;
        int                len;
        int unsigned       roll;
        round_mode_e       mode;
        logic [FACT_W-1:0] abs_set;
        logic [FACT_W-1:0] rel_set;

        random_items = 0;
        phase        = 0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Opening round: the first round after reset, as long as the longest
        // random round, so every slot read later has been written. Its first
        // three items leave slots 0..2 with known values.
        send_node(32'h0000_0000, 1'b0);
        send_node(32'h7FFF_FFFF, 1'b0);
        send_node(32'h8000_0000, 1'b0);
        for (int n = 3; n < OPEN_NODES - 1; n++)
            send_node($urandom, 1'b0);
        // first round: nothing is measured, never converged
        send_node($urandom, 1'b1, 1'b1, 32'h0, 1'b0);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].kind == STEP_REG)
                write_reg(DIRECTED[i].reg_index, DIRECTED[i].value[FACT_W-1:0]);
            else
                send_node(DIRECTED[i].value, DIRECTED[i].last, DIRECTED[i].typed,
                          DIRECTED[i].exp_error, DIRECTED[i].exp_converged);
        end

        // Random rounds in phases; each phase retunes both weights while the
        // block is drained, which also pauses the sender until all is in.
        while (random_items < RANDOM_ITEMS) begin
            case (phase % 8)
                0: begin abs_set = 24'h01_0000; rel_set = 24'h01_0000; end
                1: begin abs_set = 24'hFF_FFFF; rel_set = 24'hFF_FFFF; end
                2: begin abs_set = 24'h00_0000; rel_set = 24'h01_0000; end
                3: begin abs_set = 24'h01_0000; rel_set = 24'h00_0000; end
                4: begin abs_set = 24'h00_0001; rel_set = 24'h00_0001; end
                5: begin abs_set = 24'h00_8000; rel_set = 24'h04_0000; end
                6: begin
                    abs_set = $urandom_range(0, 24'hFF_FFFF);
                    rel_set = $urandom_range(0, 24'hFF_FFFF);
                end
                default: begin
                    abs_set = $urandom_range(0, 24'h02_0000);
                    rel_set = $urandom_range(0, 24'h02_0000);
                end
            endcase
            write_reg(REG_ABS_FACTOR, abs_set);
            write_reg(REG_REL_FACTOR, rel_set);
            // one whole phase runs with no idling on either side
            calm <= (phase == 4);

            phase_items = 0;
            while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
                roll = $urandom_range(0, 99);
                mode = (roll < 60) ? ROUND_SETTLING :
                       (roll < 85) ? ROUND_MIXED : ROUND_NOISE;
                roll = $urandom_range(0, 99);
                len  = (roll < 80) ? $urandom_range(1, 8) :
                       (roll < 97) ? $urandom_range(9, 40) : $urandom_range(41, OPEN_NODES);
                for (int n = 0; n < len; n++)
                    send_node(pick_value(mode), n == len - 1);
                phase_items  += len;
                random_items += len;
            end
            phase++;
        end

        calm <= 1'b0;
        wait_quiet();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
